[sv/lru_lfu_replacement_queue_assert.svh]
// Assertion macros for the replacement queue.
`ifndef LRU_LFU_REPLACEMENT_QUEUE_ASSERT_SVH
`define LRU_LFU_REPLACEMENT_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LRUQ_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LRUQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LRUQ_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define LRUQ_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[sv/lruq_pkg.sv]
// Shared codes for the replacement queue.
`default_nettype none
package lruq_pkg;
    typedef enum logic [1:0] {
        ACT_TOUCH  = 2'd0,
        ACT_EVICT  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam int unsigned REG_POLICY_MODE   = 0;
    localparam int unsigned REG_INITIAL_COUNT = 1;
    localparam int unsigned APB_ADDR_BITS     = 3;
    localparam int unsigned APB_DATA_BITS     = 32;
endpackage
`default_nettype wire

[sv/lruq_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lruq_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/lru_lfu_replacement_queue.sv]
// Replacement queue top level: ordered key table with LRU or LFU placement.
//
// The block holds up to CAPACITY keys, each with a saturating use count, in
// a victim order whose head is evicted first. Key and count live in one RAM
// indexed by physical slot; a small order vector of slot numbers gives the
// ordering, with the free slots parked behind the occupied ones, so removal
// and insertion only rotate slot numbers and never move RAM data. Each item
// runs through a sequencer: a lookup scan reads one slot per cycle through
// the RAM's single read port until the key (or, for an evict, the head) is
// found, an LFU touch then makes a second scan for the first entry whose
// count is higher, and for a touch a final insert state writes the entry
// and shifts the order. The result waits in an output register, so the
// next item is taken while the previous result is still stalled.
// policy_mode and initial_count sit on the APB port at byte addresses 0 and
// 4; write them only while the block is idle. No clearing pass is needed.
`default_nettype none
module lru_lfu_replacement_queue #(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // APB configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lruq_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [lruq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [lruq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                      pready,
    // input item channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           action,
    input  wire logic [KEY_BITS-1:0]                  key,
    // result item channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      was_present,
    output logic                                      victim_valid,
    output logic      [KEY_BITS-1:0]                  victim_key,
    output logic      [COUNT_BITS-1:0]                key_count,
    output logic      [$clog2(CAPACITY+1)-1:0]        fill_level,
    output logic                                      rejected_full
);
    import lruq_pkg::*;

    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
    localparam int unsigned ENT_W = KEY_BITS + COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_PLACE,
        ST_INSERT,
        ST_RESP
    } state_t;

    state_t                 state_reg;
    logic                   mode_reg;
    logic [15:0]            init_reg;
    logic [POS_W-1:0]       ord_reg [CAPACITY];
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       scan_reg;
    logic                   rd_vld_reg;
    logic [POS_W-1:0]       rd_pos_reg;
    logic [POS_W-1:0]       rd_slot_reg;
    action_t                act_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [OCC_W-1:0]       ins_pos_reg;
    logic                   was_reg;
    logic                   vic_vld_reg;
    logic [KEY_BITS-1:0]    vic_key_reg;
    logic                   rej_reg;
    logic                   out_valid_reg;

    logic [ENT_W-1:0]       rdata;
    logic [KEY_BITS-1:0]    rd_key;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic                   ram_we;
    logic                   cfg_wr;
    logic                   in_acc;
    logic                   out_acc;
    logic                   scanning;
    logic                   rd_last;
    logic                   find_hit;
    logic                   place_hit;
    logic                   issue;

    assign rd_key   = rdata[ENT_W-1 -: KEY_BITS];
    assign rd_cnt   = rdata[COUNT_BITS-1:0];
    assign ram_we   = (state_reg == ST_INSERT);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;

    // Scan bookkeeping: the data back from the RAM belongs to rd_pos_reg.
    assign rd_last   = (OCC_W'(rd_pos_reg) + OCC_W'(1)) == occ_reg;
    assign find_hit  = rd_vld_reg && ((act_reg == ACT_EVICT) || (rd_key == key_reg));
    assign place_hit = rd_vld_reg && (rd_cnt > cnt_reg);
    assign scanning  = (state_reg == ST_FIND) || (state_reg == ST_PLACE);
    assign issue     = scanning && (scan_reg < occ_reg)
                       && !((state_reg == ST_FIND) && find_hit)
                       && !((state_reg == ST_PLACE) && place_hit)
                       && !(rd_vld_reg && rd_last);

    always_comb
    begin
        prdata = '0;
        if (paddr[2])
        begin
            prdata[15:0] = init_reg;
        end
        else
        begin
            prdata[0] = mode_reg;
        end
    end

    lruq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ord_reg[CAPACITY-1]),
        .wdata ({key_reg, cnt_reg}),
        .raddr (ord_reg[scan_reg[POS_W-1:0]]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            init_reg      <= 16'd1;
            occ_reg       <= '0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < CAPACITY; j++)
            begin
                ord_reg[j] <= POS_W'(j);
            end
        end
        else
        begin
            // configuration writes
            if (cfg_wr && (paddr[2] == 1'b0))
            begin
                mode_reg <= pwdata[0];
            end
            if (cfg_wr && (paddr[2] == 1'b1))
            begin
                init_reg <= pwdata[15:0];
            end

            // scan read pipeline
            rd_vld_reg  <= issue;
            rd_pos_reg  <= scan_reg[POS_W-1:0];
            rd_slot_reg <= ord_reg[scan_reg[POS_W-1:0]];
            if (issue)
            begin
                scan_reg <= scan_reg + OCC_W'(1);
            end

            // drop the taken result unless a new one replaces it this cycle
            if (out_acc && (state_reg != ST_RESP))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        act_reg     <= action_t'(action);
                        key_reg     <= key;
                        was_reg     <= 1'b0;
                        vic_vld_reg <= 1'b0;
                        vic_key_reg <= '0;
                        rej_reg     <= 1'b0;
                        cnt_reg     <= '0;
                        scan_reg    <= '0;
                        if (action == ACT_NONE)
                        begin
                            state_reg <= ST_RESP;
                        end
                        else if (occ_reg != '0)
                        begin
                            state_reg <= ST_FIND;
                        end
                        else if (action == ACT_TOUCH)
                        begin
                            // empty table: new key goes to position zero
                            cnt_reg     <= COUNT_BITS'(init_reg);
                            ins_pos_reg <= '0;
                            state_reg   <= ST_INSERT;
                        end
                        else
                        begin
                            state_reg <= ST_RESP;
                        end
                    end
                end
                ST_FIND:
                begin
                    if (find_hit)
                    begin
                        // drop the entry: close the gap, park its slot at the end
                        for (int j = 0; j < CAPACITY - 1; j++)
                        begin
                            if (POS_W'(j) >= rd_pos_reg)
                            begin
                                ord_reg[j] <= ord_reg[j+1];
                            end
                        end
                        ord_reg[CAPACITY-1] <= rd_slot_reg;
                        occ_reg  <= occ_reg - OCC_W'(1);
                        scan_reg <= '0;
                        if (act_reg == ACT_EVICT)
                        begin
                            vic_vld_reg <= 1'b1;
                            vic_key_reg <= rd_key;
                            state_reg   <= ST_RESP;
                        end
                        else
                        begin
                            was_reg <= 1'b1;
                            if (act_reg == ACT_TOUCH)
                            begin
                                cnt_reg     <= (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
                                ins_pos_reg <= occ_reg - OCC_W'(1);
                                state_reg   <= mode_reg ? ST_PLACE : ST_INSERT;
                            end
                            else
                            begin
                                state_reg <= ST_RESP;
                            end
                        end
                    end
                    else if (rd_vld_reg && rd_last)
                    begin
                        scan_reg <= '0;
                        if (act_reg != ACT_TOUCH)
                        begin
                            state_reg <= ST_RESP;
                        end
                        else if (occ_reg == OCC_W'(CAPACITY))
                        begin
                            rej_reg   <= 1'b1;
                            state_reg <= ST_RESP;
                        end
                        else
                        begin
                            cnt_reg     <= COUNT_BITS'(init_reg);
                            ins_pos_reg <= occ_reg;
                            state_reg   <= mode_reg ? ST_PLACE : ST_INSERT;
                        end
                    end
                end
                ST_PLACE:
                begin
                    if (occ_reg == '0)
                    begin
                        ins_pos_reg <= '0;
                        state_reg   <= ST_INSERT;
                    end
                    else if (place_hit)
                    begin
                        ins_pos_reg <= OCC_W'(rd_pos_reg);
                        state_reg   <= ST_INSERT;
                    end
                    else if (rd_vld_reg && rd_last)
                    begin
                        ins_pos_reg <= occ_reg;
                        state_reg   <= ST_INSERT;
                    end
                end
                ST_INSERT:
                begin
                    // take the last free slot and open a hole at the target position
                    for (int j = 1; j < CAPACITY; j++)
                    begin
                        if (OCC_W'(j) > ins_pos_reg)
                        begin
                            ord_reg[j] <= ord_reg[j-1];
                        end
                    end
                    ord_reg[ins_pos_reg[POS_W-1:0]] <= ord_reg[CAPACITY-1];
                    occ_reg   <= occ_reg + OCC_W'(1);
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        was_present   <= was_reg;
                        victim_valid  <= vic_vld_reg;
                        victim_key    <= vic_key_reg;
                        key_count     <= ((act_reg == ACT_TOUCH) && !rej_reg) ? cnt_reg : '0;
                        fill_level    <= occ_reg;
                        rejected_full <= rej_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "lru_lfu_replacement_queue_assert.svh"
    `LRUQ_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(CAPACITY))
    `LRUQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, state_reg != ST_IDLE)
    `LRUQ_ASSERT_IMPL(a_insert_room, clk, rst_n, state_reg == ST_INSERT, occ_reg < OCC_W'(CAPACITY))
endmodule
`default_nettype wire

[sim/tb_lru_lfu_replacement_queue.sv]
// Self-checking testbench for the LRU/LFU replacement queue.
`timescale 1ns / 100ps
`default_nettype none
module tb_lru_lfu_replacement_queue;
    import lruq_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned FILL_W = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        action_t            act;
        logic [KEY_W-1:0]   k;
    } cmd_t;

    typedef struct packed {
        logic               present;
        logic               vic_ok;
        logic [KEY_W-1:0]   vic_key;
        logic [CNT_W-1:0]   cnt;
        logic [FILL_W-1:0]  fill;
        logic               rej;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = '0;
    logic [KEY_W-1:0] key = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic was_present, victim_valid, rejected_full;
    logic [KEY_W-1:0] victim_key;
    logic [CNT_W-1:0] key_count;
    logic [FILL_W-1:0] fill_level;

    lru_lfu_replacement_queue dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
        .out_valid(out_valid), .out_stall(out_stall),
        .was_present(was_present), .victim_valid(victim_valid),
        .victim_key(victim_key), .key_count(key_count),
        .fill_level(fill_level), .rejected_full(rejected_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the victim order, head at index 0.
    logic [KEY_W-1:0] order_key [DEPTH];
    logic [CNT_W-1:0] order_cnt [DEPTH];
    int unsigned      held;
    logic             lfu_mode;
    logic [CNT_W-1:0] first_count;

    cmd_t  pending_cmds [$];
    resp_t expected_resps [$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_recv = 1'b0;
    bit    in_taken = 1'b0;

    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < held; i++)
            if (order_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void unlink(int pos);
        for (int i = pos; i < int'(held) - 1; i++)
        begin
            order_key[i] = order_key[i+1];
            order_cnt[i] = order_cnt[i+1];
        end
        held--;
    endfunction

    function automatic void link(int pos, logic [KEY_W-1:0] k, logic [CNT_W-1:0] c);
        for (int i = held; i > pos; i--)
        begin
            order_key[i] = order_key[i-1];
            order_cnt[i] = order_cnt[i-1];
        end
        order_key[pos] = k;
        order_cnt[pos] = c;
        held++;
    endfunction

    // Apply one item to the shadow table and return the result it should give.
    function automatic resp_t apply_action(cmd_t c);
        resp_t r;
        int idx;
        int pos;
        logic [CNT_W-1:0] n;
        r = '0;
        idx = find_key(c.k);
        case (c.act)
            ACT_TOUCH:
            begin
                if (idx >= 0 || held < DEPTH)
                begin
                    if (idx >= 0)
                    begin
                        r.present = 1'b1;
                        n = order_cnt[idx] == CNT_MAX ? CNT_MAX : order_cnt[idx] + 1'b1;
                        unlink(idx);
                    end
                    else
                        n = first_count;
                    pos = held;
                    if (lfu_mode)
                        for (int i = held - 1; i >= 0; i--)
                            if (order_cnt[i] > n)
                                pos = i;
                    link(pos, c.k, n);
                    r.cnt = n;
                end
                else
                    r.rej = 1'b1;
            end
            ACT_EVICT:
            begin
                if (held > 0)
                begin
                    r.vic_ok = 1'b1;
                    r.vic_key = order_key[0];
                    unlink(0);
                end
            end
            ACT_REMOVE:
            begin
                if (idx >= 0)
                begin
                    r.present = 1'b1;
                    unlink(idx);
                end
            end
            default: ;
        endcase
        r.fill = FILL_W'(held);
        return r;
    endfunction

    // Driver: present the queue head, advance on acceptance, idle at random.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                ;   // hold the stalled item
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                action <= pending_cmds[0].act;
                key <= pending_cmds[0].k;
                void'(pending_cmds.pop_front());
            end
            else
                in_valid <= 1'b0;
            out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict on input acceptance, compare on output acceptance.
    always @(posedge clk)
    begin
        resp_t got;
        resp_t exp_r;
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_resps.push_back(apply_action(cmd_t'({action, key})));
            end
            if (out_valid && !out_stall)
            begin
                got = {was_present, victim_valid, victim_key, key_count, fill_level,
                       rejected_full};
                if (expected_resps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    exp_r = expected_resps.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", exp_r, got);
                    end
                end
            end
        end
    end

    task automatic reg_write(int unsigned idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= APB_ADDR_BITS'(4 * idx); pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_POLICY_MODE)
            lfu_mode = val[0];
        else
            first_count = val[CNT_W-1:0];
    endtask

    // Wait for every issued item to come back, then let the block settle.
    task automatic drain();
        wait (pending_cmds.size() == 0 && !in_valid);
        wait (expected_resps.size() == 0);
        repeat (80) @(negedge clk);
    endtask

    // Keys from a small pool so touches hit often; rarely a wild key.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(19) == 0)
            return $urandom();
        return KEY_W'($urandom_range(23));
    endfunction

    task automatic queue_random(int n);
        cmd_t c;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            c.act = r < 60 ? ACT_TOUCH : r < 78 ? ACT_EVICT : r < 97 ? ACT_REMOVE : ACT_NONE;
            c.k = pick_key();
            pending_cmds.push_back(c);
        end
    endtask

    task automatic add_cmd(action_t a, logic [KEY_W-1:0] k);
        pending_cmds.push_back(cmd_t'({a, k}));
    endtask

    initial
    begin
        held = 0;
        lfu_mode = 1'b0;
        first_count = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty evict, extremes of the key, fill to full, reject.
        reg_write(REG_INITIAL_COUNT, 32'hFFFE);
        reg_write(REG_POLICY_MODE, 1);
        add_cmd(ACT_EVICT, '1);
        add_cmd(ACT_REMOVE, 32'h0);
        add_cmd(ACT_NONE, 32'h5A5A_A5A5);
        add_cmd(ACT_TOUCH, '0);
        add_cmd(ACT_TOUCH, '1);
        add_cmd(ACT_TOUCH, '1);   // reaches saturation
        add_cmd(ACT_TOUCH, '1);   // stays saturated
        for (int i = 1; i <= 14; i++)
            add_cmd(ACT_TOUCH, KEY_W'(32'h1000 + i));
        add_cmd(ACT_TOUCH, 32'hA5A5_5A5A);   // table full: refused
        add_cmd(ACT_REMOVE, '1);
        add_cmd(ACT_EVICT, 32'h0);
        drain();

        // Random phases across settings and idling mixes.
        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(REG_POLICY_MODE, ph % 2);
            case (ph % 4)
                0: reg_write(REG_INITIAL_COUNT, 0);
                1: reg_write(REG_INITIAL_COUNT, 32'hFFFF);
                2: reg_write(REG_INITIAL_COUNT, 1);
                default: reg_write(REG_INITIAL_COUNT, $urandom_range(65535));
            endcase
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 24 : 46) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 24 : 46) : 0;
            if (ph == 2)
            begin
                // Long receiver hold-off while the sender keeps offering.
                hold_recv = 1'b1;
                queue_random(20);
                repeat (300) @(negedge clk);
                hold_recv = 1'b0;
                drain();   // sender pauses until everything is back
            end
            queue_random(210);
            drain();
        end

        if (mismatches == 0 && expected_resps.size() == 0)
            $display("tb_lru_lfu_replacement_queue: clean");
        else
            $display("tb_lru_lfu_replacement_queue: errors");
        $finish;
    end

    // Watchdog: ends the run as an error if the test never finishes.
    initial
    begin
        #20_000_000;
        $display("tb_lru_lfu_replacement_queue: errors");
        $finish;
    end
endmodule
`default_nettype wire
